/* src/srte_pkg.sv */
// ----------------------------------------------------------------------------
// srte_pkg
// Shared types, constants and helpers for the SPI ring transfer engine.
// ----------------------------------------------------------------------------
package srte_pkg;

  localparam int RING_DEPTH = 256;
  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = AW + 1;
  localparam int NW = (CW > 9) ? CW : 9;

  localparam logic [4:0] EV_DONE     = 5'h01;
  localparam logic [4:0] EV_RELEASED = 5'h02;
  localparam logic [4:0] EV_PURGED   = 5'h04;
  localparam logic [4:0] EV_PER_BYTE = 5'h08;
  localparam logic [4:0] EV_FAILED   = 5'h10;

  localparam logic [2:0] MD_TX   = 3'b001;
  localparam logic [2:0] MD_RX   = 3'b010;
  localparam logic [2:0] MD_DONE = 3'b100;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef enum logic [3:0] {
    REQ_CLAIM   = 4'd0,
    REQ_RELEASE = 4'd1,
    REQ_TICK    = 4'd2,
    REQ_TX      = 4'd3,
    REQ_RXTX    = 4'd4,
    REQ_RX      = 4'd5,
    REQ_FILT_RX = 4'd6,
    REQ_WIRE    = 4'd7,
    REQ_READ    = 4'd8,
    REQ_SKIP    = 4'd9,
    REQ_FIND    = 4'd10,
    REQ_AVAIL   = 4'd11,
    REQ_CLEAR   = 4'd12
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_POST,
    S_OFF_CAP,
    S_RD_CAP,
    S_FIND_RD,
    S_FIND_CHK,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic fill;
    logic post;
    logic off_cap;
    logic rd_cap;
    logic find_rd;
    logic find_chk;
  } cmd_t;

  typedef struct packed {
    logic rd_go;
    logic find_go;
    logic fill_done;
    logic offer_go;
    logic find_end;
    logic find_hit;
  } stat_t;

  function automatic logic [CW-1:0] ring_dist(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
    return a - b;
  endfunction

  function automatic logic [8:0] sat9(input logic [NW-1:0] v);
    return (v > NW'(511)) ? 9'd511 : v[8:0];
  endfunction

endpackage

/* src/srte_ram.sv */
// ----------------------------------------------------------------------------
// srte_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/srte_ctrl.sv */
// ----------------------------------------------------------------------------
// srte_ctrl
// Request sequencer: steps the datapath through execute, slot fill,
// shifter offer, ring read and preamble search.
// ----------------------------------------------------------------------------
module srte_ctrl import srte_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.rd_go) state_d = S_RD_CAP;
        else if (stat_i.find_go) state_d = S_FIND_RD;
        else state_d = S_FILL;
      end
      S_FILL: begin
        if (stat_i.fill_done) state_d = S_POST;
      end
      S_POST: begin
        state_d = stat_i.offer_go ? S_OFF_CAP : S_DONE;
      end
      S_OFF_CAP: state_d = S_DONE;
      S_RD_CAP:  state_d = S_DONE;
      S_FIND_RD: begin
        state_d = stat_i.find_end ? S_DONE : S_FIND_CHK;
      end
      S_FIND_CHK: begin
        state_d = stat_i.find_hit ? S_DONE : S_FIND_RD;
      end
      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EXEC:     cmd_o.exec = 1'b1;
      S_FILL:     cmd_o.fill = 1'b1;
      S_POST:     cmd_o.post = 1'b1;
      S_OFF_CAP:  cmd_o.off_cap = 1'b1;
      S_RD_CAP:   cmd_o.rd_cap = 1'b1;
      S_FIND_RD:  cmd_o.find_rd = 1'b1;
      S_FIND_CHK: cmd_o.find_chk = 1'b1;
      S_DONE:     out_valid_o = 1'b1;
      default: ;
    endcase
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_EXEC)
    else $error("accepted request not executed");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && !in_ready_o)
    else $error("result dropped before taken");

endmodule

/* src/srte_dp.sv */
// ----------------------------------------------------------------------------
// srte_dp
// Datapath: lock, ring pointers, hunt state, ring memory and result registers.
// ----------------------------------------------------------------------------
module srte_dp import srte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic        cfg_we_i,
  input  logic        invert_data_i,
  input  logic [3:0]  req_type_i,
  input  logic [3:0]  app_id_i,
  input  logic [7:0]  data_byte_i,
  input  logic [8:0]  count_i,
  input  logic [15:0] timeout_ticks_i,
  input  logic [4:0]  event_mask_i,
  input  logic [7:0]  preamble_byte_i,
  input  logic [7:0]  retry_limit_i,
  output logic        status_o,
  output logic [7:0]  data_out_o,
  output logic        shift_out_valid_o,
  output logic [8:0]  byte_count_o,
  output logic [4:0]  events_o,
  output logic        ring_empty_o
);

  logic          inv_q, inv_d;
  logic [3:0]    owner_q, owner_d;
  logic [CW-1:0] qh_q, qh_d, wp_q, wp_d, rp_q, rp_d;
  logic [2:0]    mode_q, mode_d;
  logic [4:0]    act_q, act_d, sav_q, sav_d;
  logic          hunt_q, hunt_d;
  logic [7:0]    hchar_q, hchar_d, tries_q, tries_d;
  logic [31:0]   dl_q, dl_d, now_q, now_d;
  logic          busy_q, busy_d;

  logic [3:0]    req_q, req_d, app_q, app_d;
  logic [7:0]    dat_q, dat_d, pre_q, pre_d, rlim_q, rlim_d;
  logic [8:0]    cnt_q, cnt_d;
  logic [15:0]   tmo_q, tmo_d;
  logic [4:0]    emask_q, emask_d;

  logic [NW-1:0] fill_q, fill_d;
  logic [7:0]    fval_q, fval_d;
  logic          offer_q, offer_d, wpost_q, wpost_d;

  logic          st_q, st_d, sv_q, sv_d;
  logic [7:0]    dout_q, dout_d;
  logic [8:0]    bc_q, bc_d;
  logic [4:0]    ev_q, ev_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic          owner_ok, need_owner;
  logic [7:0]    wf_in;
  logic [CW-1:0] ring_depth_c;

  assign ring_depth_c = CW'(RING_DEPTH);
  assign owner_ok     = app_q == owner_q;
  assign need_owner   = !(req_q == REQ_CLAIM || req_q == REQ_TICK || req_q == REQ_WIRE);
  assign wf_in        = inv_q ? (BYTE_ONES - dat_q) : dat_q;

  srte_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    stat_o.rd_go     = req_q == REQ_READ && owner_ok && rp_q != wp_q;
    stat_o.find_go   = req_q == REQ_FIND && owner_ok;
    stat_o.fill_done = fill_q == '0;
    stat_o.offer_go  = (offer_q || wpost_q) && !busy_q && wp_q != qh_q;
    stat_o.find_end  = rp_q == wp_q;
    stat_o.find_hit  = ram_rdata == pre_q;
  end

  always_comb begin
    logic [CW-1:0] wn;
    logic [CW-1:0] rn;
    logic [NW-1:0] freev;
    logic [NW-1:0] n;
    logic [7:0]    tn;
    logic [31:0]   now_n;

    inv_d = cfg_we_i ? invert_data_i : inv_q;
    owner_d = owner_q; qh_d = qh_q; wp_d = wp_q; rp_d = rp_q;
    mode_d = mode_q; act_d = act_q; sav_d = sav_q; hunt_d = hunt_q;
    hchar_d = hchar_q; tries_d = tries_q; dl_d = dl_q; now_d = now_q;
    busy_d = busy_q;
    req_d = req_q; app_d = app_q; dat_d = dat_q; pre_d = pre_q; rlim_d = rlim_q;
    cnt_d = cnt_q; tmo_d = tmo_q; emask_d = emask_q;
    fill_d = fill_q; fval_d = fval_q; offer_d = offer_q; wpost_d = wpost_q;
    st_d = st_q; sv_d = sv_q; dout_d = dout_q; bc_d = bc_q; ev_d = ev_q;
    ram_we = 1'b0;
    ram_waddr = qh_q[AW-1:0];
    ram_wdata = fval_q;
    ram_raddr = rp_q[AW-1:0];
    wn = wp_q + CW'(1);
    rn = rp_q;
    freev = '0;
    n = '0;
    tn = tries_q - 8'd1;
    now_n = now_q + 32'd1;

    if (cmd_i.load) begin
      req_d = req_type_i; app_d = app_id_i; dat_d = data_byte_i; cnt_d = count_i;
      tmo_d = timeout_ticks_i; emask_d = event_mask_i; pre_d = preamble_byte_i;
      rlim_d = retry_limit_i;
      fill_d = '0; offer_d = 1'b0; wpost_d = 1'b0;
      st_d = 1'b0; sv_d = 1'b0; dout_d = BYTE_ZERO; bc_d = '0; ev_d = '0;
    end

    if (cmd_i.exec) begin
      if (need_owner && req_q <= REQ_CLEAR && !owner_ok) begin
        st_d = 1'b1;
      end else begin
        case (req_q)
          REQ_CLAIM: begin
            if (owner_q == '0) begin
              owner_d = app_q; act_d = emask_q;
              dl_d = now_q + {16'd0, tmo_q};
              hunt_d = 1'b0; sav_d = '0; tries_d = '0;
            end else begin
              st_d = 1'b1;
            end
          end
          REQ_RELEASE, REQ_TICK: begin
            if (req_q == REQ_TICK) now_d = now_n;
            if (req_q == REQ_RELEASE || (owner_q != '0 && now_n > dl_q)) begin
              if (req_q == REQ_TICK) ev_d = act_q & (EV_RELEASED | EV_PURGED);
              else ev_d = act_q & EV_RELEASED;
              if (mode_q != '0) begin
                rp_d = qh_q; wp_d = qh_q;
              end
              owner_d = '0; act_d = '0; dl_d = '0; mode_d = '0;
            end
          end
          REQ_WIRE: begin
            busy_d = 1'b0;
            if (mode_q != '0 && wp_q != qh_q) begin
              ram_we = 1'b1;
              ram_waddr = wp_q[AW-1:0];
              ram_wdata = wf_in;
              wp_d = wn;
              wpost_d = 1'b1;
              if ((act_q & EV_PER_BYTE) != '0) begin
                if (hunt_q) begin
                  if (wf_in == hchar_q) begin
                    hunt_d = 1'b0; act_d = sav_q; tries_d = '0;
                  end else begin
                    tries_d = tn;
                    if (tn != '0) begin
                      if (rp_q != wn) rn = rp_q + CW'(1);
                      rp_d = rn;
                      freev = NW'(ring_depth_c - ring_dist(qh_q, rn));
                      fill_d = (freev != '0) ? NW'(1) : '0;
                      fval_d = BYTE_ZERO;
                    end else begin
                      rp_d = qh_q; wp_d = qh_q;
                      hunt_d = 1'b0; act_d = sav_q; tries_d = '0;
                      ev_d = EV_FAILED;
                    end
                  end
                end else begin
                  ev_d = EV_PER_BYTE;
                end
              end
            end
          end
          REQ_TX, REQ_RXTX: begin
            mode_d = (req_q == REQ_TX) ? ((mode_q | MD_TX) & ~MD_RX) : (mode_q | MD_TX | MD_RX);
            freev = NW'(ring_depth_c - ring_dist(qh_q, rp_q));
            n = (freev != '0) ? NW'(1) : '0;
            fill_d = n; fval_d = dat_q; bc_d = sat9(n); offer_d = 1'b1;
          end
          REQ_RX, REQ_FILT_RX: begin
            mode_d = (mode_q | MD_RX) & ~MD_TX;
            freev = NW'(ring_depth_c - ring_dist(qh_q, rp_q));
            n = (NW'(cnt_q) > freev) ? freev : NW'(cnt_q);
            fill_d = n; fval_d = BYTE_ZERO; bc_d = sat9(n); offer_d = 1'b1;
            if (req_q == REQ_FILT_RX) begin
              hunt_d = 1'b1; hchar_d = pre_q; sav_d = act_q;
              act_d = act_q | EV_PER_BYTE; tries_d = rlim_q;
            end
          end
          REQ_SKIP: begin
            if (NW'(ring_dist(wp_q, rp_q)) < NW'(cnt_q)) begin
              rp_d = wp_q; mode_d = '0;
            end else begin
              rp_d = rp_q + CW'(cnt_q);
            end
          end
          REQ_CLEAR: begin
            rp_d = qh_q; wp_d = qh_q;
          end
          default: ;
        endcase
      end
    end

    if (cmd_i.fill && fill_q != '0) begin
      ram_we = 1'b1;
      qh_d = qh_q + CW'(1);
      fill_d = fill_q - NW'(1);
    end

    if (cmd_i.post) begin
      ram_raddr = wp_q[AW-1:0];
      if (wpost_q && wp_q == qh_q) begin
        mode_d = mode_q | MD_DONE;
        ev_d = ev_q | (act_q & EV_DONE);
        if ((mode_q & MD_RX) == '0) rp_d = wp_q;
      end
    end

    if (cmd_i.off_cap) begin
      dout_d = inv_q ? (BYTE_ONES - ram_rdata) : ram_rdata;
      sv_d = 1'b1;
      busy_d = 1'b1;
    end

    if (cmd_i.rd_cap) begin
      rn = rp_q + CW'(1);
      dout_d = ram_rdata;
      rp_d = rn;
      bc_d = 9'd1;
      if (rn == wp_q) mode_d = '0;
    end

    if (cmd_i.find_rd && rp_q == wp_q) mode_d = '0;

    if (cmd_i.find_chk && ram_rdata != pre_q) rp_d = rp_q + CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0; owner_q <= '0; qh_q <= '0; wp_q <= '0; rp_q <= '0;
      mode_q <= '0; act_q <= '0; sav_q <= '0; hunt_q <= 1'b0; hchar_q <= '0;
      tries_q <= '0; dl_q <= '0; now_q <= '0; busy_q <= 1'b0;
      fill_q <= '0; offer_q <= 1'b0; wpost_q <= 1'b0;
    end else begin
      inv_q <= inv_d; owner_q <= owner_d; qh_q <= qh_d; wp_q <= wp_d; rp_q <= rp_d;
      mode_q <= mode_d; act_q <= act_d; sav_q <= sav_d; hunt_q <= hunt_d;
      hchar_q <= hchar_d; tries_q <= tries_d; dl_q <= dl_d; now_q <= now_d;
      busy_q <= busy_d; fill_q <= fill_d; offer_q <= offer_d; wpost_q <= wpost_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; app_q <= app_d; dat_q <= dat_d; pre_q <= pre_d; rlim_q <= rlim_d;
    cnt_q <= cnt_d; tmo_q <= tmo_d; emask_q <= emask_d; fval_q <= fval_d;
    st_q <= st_d; sv_q <= sv_d; dout_q <= dout_d; bc_q <= bc_d; ev_q <= ev_d;
  end

  assign status_o          = st_q;
  assign data_out_o        = dout_q;
  assign shift_out_valid_o = sv_q;
  assign events_o          = ev_q;
  assign ring_empty_o      = rp_q == wp_q;
  assign byte_count_o      = (!st_q && (req_q == REQ_SKIP || req_q == REQ_FIND ||
                              req_q == REQ_AVAIL)) ? sat9(NW'(ring_dist(wp_q, rp_q))) : bc_q;

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_dist(qh_q, rp_q) <= ring_depth_c)
    else $error("ring over-filled");

  a_rx_in_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_dist(wp_q, rp_q) <= ring_dist(qh_q, rp_q))
    else $error("wire pointer beyond queue head");

endmodule

/* src/spi_ring_transfer_engine_top.sv */
// ----------------------------------------------------------------------------
// spi_ring_transfer_engine_top
// SPI master front end: owner lock, shared tx/rx byte ring, preamble hunt.
// ----------------------------------------------------------------------------
// channel | handshake              | payload
// in      | in_valid_i/in_ready_o  | req_type_i .. retry_limit_i
// out     | out_valid_o/out_ready_i| status_o .. ring_empty_o
// cfg     | cfg_valid_i/cfg_ready_o| invert_data_i
//
// One request at a time: a request runs execute, then slot fill, post
// and an optional shifter offer; a read captures one ring entry and a find
// walks the ring entry by entry. Then the result waits until it is taken.
// Slot fill uses the ring write port and the find walk its read port.
// Reset clears lock, pointers and flags; ring contents are not cleared.
// cfg is always ready; in_ready drops until the result is taken.
module spi_ring_transfer_engine_top import srte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        invert_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  req_type_i,
  input  logic [3:0]  app_id_i,
  input  logic [7:0]  data_byte_i,
  input  logic [8:0]  count_i,
  input  logic [15:0] timeout_ticks_i,
  input  logic [4:0]  event_mask_i,
  input  logic [7:0]  preamble_byte_i,
  input  logic [7:0]  retry_limit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [7:0]  data_out_o,
  output logic        shift_out_valid_o,
  output logic [8:0]  byte_count_o,
  output logic [4:0]  events_o,
  output logic        ring_empty_o
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  srte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  srte_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_valid_i),
    .invert_data_i    (invert_data_i),
    .req_type_i       (req_type_i),
    .app_id_i         (app_id_i),
    .data_byte_i      (data_byte_i),
    .count_i          (count_i),
    .timeout_ticks_i  (timeout_ticks_i),
    .event_mask_i     (event_mask_i),
    .preamble_byte_i  (preamble_byte_i),
    .retry_limit_i    (retry_limit_i),
    .status_o         (status_o),
    .data_out_o       (data_out_o),
    .shift_out_valid_o(shift_out_valid_o),
    .byte_count_o     (byte_count_o),
    .events_o         (events_o),
    .ring_empty_o     (ring_empty_o)
  );

endmodule

/* tb/sv/tb_spi_ring_transfer_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_ring_transfer_engine_top
// Self-checking bench for the SPI ring transfer engine. It applies a short
// table of directed requests, then random claim/queue/wire/read traffic
// in four phases with invert_data toggled between phases. Random stalls
// hit both channels. Each result is compared with its typed table reply
// or an in-bench model of the owner lock, shared ring and preamble hunt.
// ----------------------------------------------------------------------------
module tb_spi_ring_transfer_engine_top;
  import srte_pkg::*;

  typedef struct packed {
    logic [3:0]  req;
    logic [3:0]  app;
    logic [7:0]  data;
    logic [8:0]  cnt;
    logic [15:0] tmo;
    logic [4:0]  mask;
    logic [7:0]  pre;
    logic [7:0]  rlim;
  } request_t;

  typedef struct packed {
    logic       status;
    logic [7:0] data;
    logic       sov;
    logic [8:0] bc;
    logic [4:0] ev;
    logic       empty;
  } reply_t;

  typedef struct {
    request_t rq;
    bit       typed;
    reply_t   rep;
  } dir_row_t;

  localparam int RAND_ITEMS = 1700;
  localparam int STALL_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic invert_data_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [3:0] req_type_i = '0;
  logic [3:0] app_id_i = '0;
  logic [7:0] data_byte_i = '0;
  logic [8:0] count_i = '0;
  logic [15:0] timeout_ticks_i = '0;
  logic [4:0] event_mask_i = '0;
  logic [7:0] preamble_byte_i = '0;
  logic [7:0] retry_limit_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o;
  logic [7:0] data_out_o;
  logic shift_out_valid_o;
  logic [8:0] byte_count_o;
  logic [4:0] events_o;
  logic ring_empty_o;

  always #5 clk_i = ~clk_i;

  spi_ring_transfer_engine_top DUT (.*);

  // model state
  logic        m_inv;
  logic [3:0]  m_owner;
  logic [7:0]  m_ring [RING_DEPTH];
  logic [8:0]  m_qh, m_wp, m_rp;
  logic [2:0]  m_mode;
  logic [4:0]  m_amask, m_smask;
  logic        m_hunt;
  logic [7:0]  m_hchar, m_tries;
  logic [31:0] m_deadline, m_now;
  logic        m_busy;

  reply_t expected_q[$];
  int     mismatches = 0;
  bit     quiet = 0;
  int     stall_cycles = 0;

  function automatic logic [7:0] wform(logic [7:0] b);
    return m_inv ? BYTE_ONES - b : b;
  endfunction

  function automatic void offer(inout reply_t r);
    if (!m_busy && m_wp != m_qh) begin
      r.data = wform(m_ring[m_wp[7:0]]);
      r.sov = 1'b1;
      m_busy = 1'b1;
    end
  endfunction

  function automatic int queue_slots(int n, logic [7:0] v);
    int f;
    f = RING_DEPTH - int'(9'(m_qh - m_rp));
    if (n > f) n = f;
    for (int i = 0; i < n; i++) begin
      m_ring[m_qh[7:0]] = v;
      m_qh = m_qh + 9'd1;
    end
    return n;
  endfunction

  function automatic void release_lock(inout reply_t r);
    if (m_mode != 3'd0) begin
      m_rp = m_qh;
      m_wp = m_qh;
    end
    r.ev |= m_amask & EV_RELEASED;
    m_owner = '0;
    m_amask = '0;
    m_deadline = '0;
    m_mode = '0;
  endfunction

  function automatic void end_hunt();
    m_hunt = 1'b0;
    m_amask = m_smask;
    m_tries = '0;
  endfunction

  function automatic void take_wire_byte(logic [7:0] b, inout reply_t r);
    m_busy = 1'b0;
    if (m_mode == 3'd0 || m_wp == m_qh) return;
    m_ring[m_wp[7:0]] = wform(b);
    m_wp = m_wp + 9'd1;
    if (m_amask & EV_PER_BYTE) begin
      if (m_hunt) begin
        if (m_ring[8'(m_wp - 9'd1)] == m_hchar) begin
          end_hunt();
        end else begin
          m_tries = m_tries - 8'd1;
          if (m_tries != 8'd0) begin
            if (m_rp != m_wp) m_rp = m_rp + 9'd1;
            void'(queue_slots(1, BYTE_ZERO));
          end else begin
            m_rp = m_qh;
            m_wp = m_qh;
            end_hunt();
            r.ev |= EV_FAILED;
          end
        end
      end else begin
        r.ev |= EV_PER_BYTE;
      end
    end
    if (m_wp != m_qh) begin
      offer(r);
    end else begin
      m_mode |= MD_DONE;
      r.ev |= m_amask & EV_DONE;
      if (!(m_mode & MD_RX)) m_rp = m_wp;
    end
  endfunction

  function automatic reply_t predict_reply(request_t q);
    reply_t r;
    int bc;
    r = '0;
    bc = 0;
    if (q.req == REQ_CLAIM) begin
      if (m_owner == '0) begin
        m_owner = q.app;
        m_amask = q.mask;
        m_deadline = m_now + 32'(q.tmo);
        m_hunt = 1'b0;
        m_smask = '0;
        m_tries = '0;
      end else begin
        r.status = 1'b1;
      end
    end else if (q.req == REQ_TICK) begin
      m_now = m_now + 32'd1;
      if (m_owner != '0 && m_now > m_deadline) begin
        r.ev |= m_amask & (EV_RELEASED | EV_PURGED);
        release_lock(r);
      end
    end else if (q.req == REQ_WIRE) begin
      take_wire_byte(q.data, r);
    end else if (q.req <= REQ_CLEAR) begin
      if (q.app != m_owner) begin
        r.status = 1'b1;
      end else if (q.req == REQ_RELEASE) begin
        release_lock(r);
      end else if (q.req == REQ_TX || q.req == REQ_RXTX) begin
        m_mode |= MD_TX;
        if (q.req == REQ_TX) m_mode &= ~MD_RX;
        else m_mode |= MD_RX;
        bc = queue_slots(1, q.data);
        offer(r);
      end else if (q.req == REQ_RX || q.req == REQ_FILT_RX) begin
        m_mode |= MD_RX;
        m_mode &= ~MD_TX;
        bc = queue_slots(int'(q.cnt), BYTE_ZERO);
        if (q.req == REQ_FILT_RX) begin
          m_hunt = 1'b1;
          m_hchar = q.pre;
          m_smask = m_amask;
          m_amask |= EV_PER_BYTE;
          m_tries = q.rlim;
        end
        offer(r);
      end else if (q.req == REQ_READ) begin
        if (m_rp != m_wp) begin
          r.data = m_ring[m_rp[7:0]];
          m_rp = m_rp + 9'd1;
          bc = 1;
          if (m_rp == m_wp) m_mode = '0;
        end
      end else if (q.req == REQ_SKIP) begin
        if (int'(9'(m_wp - m_rp)) < int'(q.cnt)) begin
          m_rp = m_wp;
          m_mode = '0;
        end else begin
          m_rp = m_rp + q.cnt;
        end
        bc = int'(9'(m_wp - m_rp));
      end else if (q.req == REQ_FIND) begin
        while (m_rp != m_wp && m_ring[m_rp[7:0]] != q.pre) m_rp = m_rp + 9'd1;
        if (m_rp == m_wp) m_mode = '0;
        bc = int'(9'(m_wp - m_rp));
      end else if (q.req == REQ_AVAIL) begin
        bc = int'(9'(m_wp - m_rp));
      end else begin
        m_rp = m_qh;
        m_wp = m_qh;
      end
    end
    r.bc = (bc > 511) ? 9'd511 : 9'(bc);
    r.empty = (m_rp == m_wp);
    return r;
  endfunction

  function automatic request_t mk(req_e t, int app, int data = 0, int cnt = 0, int tmo = 0,
                                  int mask = 0, int pre = 0, int rlim = 0);
    request_t q;
    q.req = t;
    q.app = 4'(app);
    q.data = 8'(data);
    q.cnt = 9'(cnt);
    q.tmo = 16'(tmo);
    q.mask = 5'(mask);
    q.pre = 8'(pre);
    q.rlim = 8'(rlim);
    return q;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] pool [4] = '{8'h00, 8'hFF, 8'h3C, 8'hA5};
    return ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 3)] : 8'($urandom);
  endfunction

  function automatic request_t random_request();
    request_t q;
    int r;
    q = '0;
    r = $urandom_range(0, 99);
    q.req = r < 8 ? REQ_CLAIM : r < 11 ? REQ_RELEASE : r < 18 ? REQ_TICK :
            r < 28 ? REQ_TX : r < 36 ? REQ_RXTX : r < 44 ? REQ_RX :
            r < 52 ? REQ_FILT_RX : r < 78 ? REQ_WIRE : r < 84 ? REQ_READ :
            r < 88 ? REQ_SKIP : r < 92 ? REQ_FIND : r < 96 ? REQ_AVAIL : REQ_CLEAR;
    if (q.req == REQ_CLAIM && m_owner == '0)
      q.app = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
    else
      q.app = ($urandom_range(0, 99) < 85) ? m_owner : 4'($urandom);
    q.data = pick_byte();
    q.pre = pick_byte();
    r = $urandom_range(0, 99);
    q.cnt = r < 90 ? 9'($urandom_range(0, 6)) : r < 95 ? 9'd256 : 9'($urandom_range(0, 256));
    r = $urandom_range(0, 99);
    q.tmo = r < 70 ? 16'($urandom_range(0, 60)) : r < 85 ? 16'hFFFF : 16'($urandom);
    q.mask = 5'($urandom);
    r = $urandom_range(0, 99);
    q.rlim = r < 80 ? 8'($urandom_range(1, 6)) : r < 90 ? 8'd0 : 8'($urandom);
    return q;
  endfunction

  task automatic send_request(request_t q, bit typed = 0, reply_t rep = '0);
    reply_t p;
    in_valid_i <= 1'b1;
    req_type_i <= q.req;
    app_id_i <= q.app;
    data_byte_i <= q.data;
    count_i <= q.cnt;
    timeout_ticks_i <= q.tmo;
    event_mask_i <= q.mask;
    preamble_byte_i <= q.pre;
    retry_limit_i <= q.rlim;
    do @(posedge clk_i); while (!in_ready_o);
    p = predict_reply(q);
    expected_q.push_back(typed ? rep : p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic write_invert(logic v);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    invert_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    m_inv = v;
    cfg_valid_i <= 1'b0;
  endtask

  // result check and receiver stalls
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      reply_t got, exp;
      got = '{status_o, data_out_o, shift_out_valid_o, byte_count_o, events_o,
              ring_empty_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp = expected_q.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp, got);
        end
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_cycles <= $urandom_range(0, 5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake on the in, out or cfg channel
  int idle_run = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    dir_row_t tab[$];
    m_inv = 0; m_owner = '0; m_qh = '0; m_wp = '0; m_rp = '0; m_mode = '0;
    m_amask = '0; m_smask = '0; m_hunt = 0; m_hchar = '0; m_tries = '0;
    m_deadline = '0; m_now = '0; m_busy = 0;
    foreach (m_ring[i]) m_ring[i] = '0;

    tab.push_back('{mk(REQ_AVAIL, 0), 1, '{1'b0, 8'h00, 1'b0, 9'd0, 5'd0, 1'b1}});
    tab.push_back('{mk(REQ_CLAIM, 5, 0, 0, 3, 31), 1, '{1'b0, 8'h00, 1'b0, 9'd0, 5'd0, 1'b1}});
    tab.push_back('{mk(REQ_CLAIM, 6), 1, '{1'b1, 8'h00, 1'b0, 9'd0, 5'd0, 1'b1}});
    tab.push_back('{mk(REQ_READ, 6), 1, '{1'b1, 8'h00, 1'b0, 9'd0, 5'd0, 1'b1}});
    tab.push_back('{mk(REQ_TX, 5, 8'hFF), 0, '0});
    tab.push_back('{mk(REQ_WIRE, 0, 8'h00), 0, '0});
    tab.push_back('{mk(REQ_RXTX, 5, 8'h00), 0, '0});
    tab.push_back('{mk(REQ_WIRE, 0, 8'hFF), 0, '0});
    tab.push_back('{mk(REQ_RX, 5, 0, 2), 0, '0});
    tab.push_back('{mk(REQ_WIRE, 0, 8'hA5), 0, '0});
    tab.push_back('{mk(REQ_WIRE, 0, 8'hA5), 0, '0});
    tab.push_back('{mk(REQ_READ, 5), 0, '0});
    tab.push_back('{mk(REQ_FIND, 5, 0, 0, 0, 0, 8'hA5), 0, '0});
    tab.push_back('{mk(REQ_SKIP, 5, 0, 256), 0, '0});
    tab.push_back('{mk(REQ_FILT_RX, 5, 0, 1, 0, 0, 8'h3C, 0), 0, '0});
    tab.push_back('{mk(REQ_WIRE, 0, 8'h11), 0, '0});
    tab.push_back('{mk(REQ_WIRE, 0, 8'h3C), 0, '0});
    tab.push_back('{mk(REQ_CLEAR, 5), 0, '0});
    tab.push_back('{mk(REQ_FILT_RX, 5, 0, 1, 0, 0, 8'h3C, 2), 0, '0});
    tab.push_back('{mk(REQ_WIRE, 0, 8'h00), 0, '0});
    tab.push_back('{mk(REQ_WIRE, 0, 8'h00), 0, '0});
    tab.push_back('{mk(REQ_RX, 5, 0, 256), 0, '0});
    tab.push_back('{mk(REQ_CLEAR, 5), 0, '0});
    tab.push_back('{mk(REQ_RELEASE, 5), 0, '0});
    tab.push_back('{mk(REQ_CLAIM, 15, 0, 0, 65535, 31, 8'hFF, 255), 0, '0});
    tab.push_back('{mk(REQ_TICK, 0), 0, '0});
    tab.push_back('{mk(REQ_RELEASE, 15), 0, '0});
    tab.push_back('{mk(REQ_CLAIM, 9, 0, 0, 0, 31), 0, '0});
    tab.push_back('{mk(REQ_TICK, 0), 0, '0});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_invert(1'b0);
    foreach (tab[i]) send_request(tab[i].rq, tab[i].typed, tab[i].rep);

    for (int ph = 0; ph < 4; ph++) begin
      write_invert(ph[0] ? 1'b0 : 1'b1);
      for (int i = 0; i < RAND_ITEMS / 4; i++) begin
        if (ph == 3 && i >= RAND_ITEMS / 4 - 150) quiet = 1;
        send_request(random_request());
      end
    end
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/srte_pkg.sv
src/srte_ram.sv
src/srte_ctrl.sv
src/srte_dp.sv
src/spi_ring_transfer_engine_top.sv
tb/sv/tb_spi_ring_transfer_engine_top.sv
